FILE: rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared types and constants of the ordered list engine
// Command codes, status codes, the per-cell operation and the control bundle
// that the top level broadcasts to every cell.
// ----------------------------------------------------------------------------
package bole_pkg;

   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;
   localparam int CMD_W  = 3;
   localparam int POS_W  = 4;
   localparam int STAT_W = 2;

   localparam logic signed [DATA_W-1:0] MISS_DATA = -32'sd999;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND   = 3'd0,
      CMD_PUSH     = 3'd1,
      CMD_POP      = 3'd2,
      CMD_REMOVE   = 3'd3,
      CMD_CONTAINS = 3'd4,
      CMD_READ     = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_MISS  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE        = 3'd0,
      OP_APPEND      = 3'd1,
      OP_PUSH        = 3'd2,
      OP_SHIFT_ALL   = 3'd3,
      OP_SHIFT_MATCH = 3'd4
   } cell_op_type;

   // broadcast to all cells; key is the search key while sampling and the
   // value to load while executing
   typedef struct packed {
      cell_op_type               op;
      logic                      sample;
      logic signed [DATA_W-1:0]  key;
   } cell_ctl_type;

endpackage

FILE: rtl/bole_cell.sv
// ----------------------------------------------------------------------------
// bole_cell: one storage cell of the ordered list
// Holds one entry, compares it with the search key and passes the
// first-match chain and its entry on to its neighbors.
// ----------------------------------------------------------------------------
module bole_cell
   import bole_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic [CNT_W-1:0]         count,
   input  logic signed [DATA_W-1:0] left_entry,
   input  logic signed [DATA_W-1:0] right_entry,
   input  logic                     match_prev,
   output logic                     match_next,
   output logic signed [DATA_W-1:0] entry
);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     match_ff, match_in;
   logic                     occupied;
   logic                     match_incl;

   assign occupied   = CNT_W'(INDEX) < count;
   assign match_incl = match_prev | match_ff;
   assign match_next = match_incl;
   assign entry      = entry_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.sample) begin
         match_in = occupied && (entry_ff == ctl.key);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         OP_APPEND: begin
            if (CNT_W'(INDEX) == count) begin
               entry_in = ctl.key;
            end
         end
         OP_PUSH: begin
            entry_in = left_entry;
         end
         OP_SHIFT_ALL: begin
            entry_in = right_entry;
         end
         OP_SHIFT_MATCH: begin
            // close up behind the first match
            if (match_incl) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

endmodule

FILE: rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: ordered list of signed identifiers
// Up to DEPTH entries held in a row of cells, with append, insert at head,
// remove head, remove by key, membership test and read by position.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the req_ channel (valid/ready) and each produces
//   exactly one result on the rsp_ channel (valid/ready), in order.
//   In the cycle of the transfer every cell compares its entry with
//   req_value; in the execute state that follows, the first-match chain across
//   the cells settles and all cells shift, load or hold together while the
//   result is written to the output register. One command is in flight at a
//   time, so a new command is taken only once the last one has executed; the
//   rsp_ register lets the next command transfer while a result still waits.
//   If the receiver stalls, the execute cycle holds until the output register
//   frees up, and req_ready stays low meanwhile.
//   Reset empties the list and drops any pending result; entry contents are
//   not cleared, since positions at or beyond the length are never read.
//   rsp_length reports the low 5 bits of the entry count.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine
   import bole_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic                     rsp_found,
   output logic [LEN_W-1:0]         rsp_length,
   output logic [STAT_W-1:0]        rsp_status
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int RD_N   = (DEPTH < 16) ? DEPTH : 16;
   localparam int RD_W   = $clog2(RD_N);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CMD_W-1:0]         cmd_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [POS_W-1:0]         pos_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff;

   logic                     req_xfer;
   logic                     exec_fire;
   cell_op_type              exec_op;
   cell_ctl_type             ctl;
   logic                     full, empty, any_match, pos_hit;

   logic signed [DATA_W-1:0] ent [DEPTH];
   logic                     chain [DEPTH+1];
   logic signed [DATA_W-1:0] rd_ent [RD_N];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign ctl.op     = exec_fire ? exec_op : OP_NONE;
   assign ctl.sample = req_xfer;
   assign ctl.key    = (state_ff == ST_IDLE) ? req_value : val_ff;

   assign chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = ctl.key;
      end else begin : g_mid
         assign left_d = ent[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_d = ent[i];
      end else begin : g_inner
         assign right_d = ent[i+1];
      end
      bole_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .left_entry  (left_d),
         .right_entry (right_d),
         .match_prev  (chain[i]),
         .match_next  (chain[i+1]),
         .entry       (ent[i])
      );
   end

   for (genvar k = 0; k < RD_N; k++) begin : g_rd
      assign rd_ent[k] = ent[k];
   end

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign any_match = chain[DEPTH];
   assign pos_hit   = CMP_W'(pos_ff) < CMP_W'(count_ff);

   always_comb begin
      exec_op       = OP_NONE;
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = STAT_OK;
      case (cmd_ff)
         CMD_APPEND, CMD_PUSH: begin
            if (full) begin
               rsp_status_in = STAT_FULL;
            end else begin
               exec_op  = (cmd_ff == CMD_APPEND) ? OP_APPEND : OP_PUSH;
               count_in = count_ff + CNT_W'(1);
            end
         end
         CMD_POP: begin
            if (empty) begin
               rsp_data_in   = MISS_DATA;
               rsp_status_in = STAT_MISS;
            end else begin
               exec_op      = OP_SHIFT_ALL;
               count_in     = count_ff - CNT_W'(1);
               rsp_data_in  = ent[0];
               rsp_found_in = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (any_match) begin
               exec_op      = OP_SHIFT_MATCH;
               count_in     = count_ff - CNT_W'(1);
               rsp_found_in = 1'b1;
            end else begin
               rsp_status_in = STAT_MISS;
            end
         end
         CMD_CONTAINS: begin
            if (any_match) begin
               rsp_found_in = 1'b1;
            end else begin
               rsp_status_in = STAT_MISS;
            end
         end
         CMD_READ: begin
            if (pos_hit) begin
               rsp_data_in  = rd_ent[pos_ff[RD_W-1:0]];
               rsp_found_in = 1'b1;
            end else begin
               rsp_data_in   = MISS_DATA;
               rsp_status_in = STAT_MISS;
            end
         end
         default: begin
            rsp_status_in = STAT_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            count_ff <= count_in;
         end
      end
   end

   // command and result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= req_command;
         val_ff <= req_value;
         pos_ff <= req_position;
      end
      if (exec_fire) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_length = LEN_W'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_xfer_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_EXEC))
      else $error("accepted command did not enter execute");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !exec_fire |=> $stable(count_ff))
      else $error("entry count changed outside execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec_fire))
      else $error("result appeared without an executed command");

endmodule
